>>> hdl/ipv4_forward_and_echo_reply_rewrite_core_assert.svh
// Assertion macros shared by the IPv4 forward / echo reply rewrite RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef IPV4_FORWARD_AND_ECHO_REPLY_REWRITE_CORE_ASSERT_SVH
`define IPV4_FORWARD_AND_ECHO_REPLY_REWRITE_CORE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define IPFW_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IPFW_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ipfw_pkg.sv
// Types and constants for the IPv4 forward / echo reply header rewrite.
// No dependencies; imported by every module of the block.
package ipfw_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP        = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [7:0]  REPLY_TTL         = 8'd64;

  localparam logic [47:0] RST_NEXT_HOP_MAC0 = 48'h000C_299D_778C;
  localparam logic [47:0] RST_NEXT_HOP_MAC1 = 48'h000C_29E1_2D7D;
  localparam logic [31:0] RST_OWN_IP0       = 32'hC0A8_0B01;
  localparam logic [31:0] RST_OWN_IP1       = 32'hC0A8_0C01;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [1:0] {
    ACT_DROP    = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_REPLY   = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_MAC0      = 3'd0,
    REG_OWN_MAC1      = 3'd1,
    REG_NEXT_HOP_MAC0 = 3'd2,
    REG_NEXT_HOP_MAC1 = 3'd3,
    REG_OWN_IP0       = 3'd4,
    REG_OWN_IP1       = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [47:0] own_mac0;
    logic [47:0] own_mac1;
    logic [47:0] next_hop_mac0;
    logic [47:0] next_hop_mac1;
    logic [31:0] own_ip0;
    logic [31:0] own_ip1;
  } cfg_t;

  // classified beat leaving the first stage
  typedef struct packed {
    logic        valid;
    action_t     action;
    logic        tx_port;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  icmp_msg;
    logic [15:0] icmp_cks;
    logic [17:0] front_sum;
  } cls_t;

endpackage

>>> hdl/ipv4_forward_and_echo_reply_rewrite_core.sv
// Top level of the IPv4 forward / echo reply header rewrite block.
// Depends on ipfw_pkg, ipfw_cfg_regs, ipfw_classify and ipfw_rewrite.
//
// Takes one parsed header per clock on start and returns exactly one result
// per header, marked by out_strobe once the beat has passed the three register
// stages (classify, rewrite and sum, checksum fold). The receiver cannot stall,
// and neither does the block: busy is high only during reset and in the cycle
// after it, so a new header may follow every cycle. Drops come out as a result
// with action zero and all fields zero. Register writes on cfg_valid/cfg_ready
// take effect at the next clock edge and must be made while no header is in
// flight; indexes past the register list are ignored.
module ipv4_forward_and_echo_reply_rewrite_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ipfw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ipfw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             rx_port,
  input  logic [15:0]                      frame_type,
  input  logic [63:0]                      ip_front_bytes,
  input  logic [7:0]                       ttl_in,
  input  logic [7:0]                       protocol,
  input  logic [15:0]                      ip_checksum_in,
  input  logic [31:0]                      src_ip_in,
  input  logic [31:0]                      dst_ip_in,
  input  logic [7:0]                       icmp_msg_in,
  input  logic [15:0]                      icmp_checksum_in,
  output logic                             out_strobe,
  output logic [1:0]                       action,
  output logic                             tx_port,
  output logic [47:0]                      dst_mac_out,
  output logic [47:0]                      src_mac_out,
  output logic [7:0]                       ttl_out,
  output logic [15:0]                      ip_checksum_out,
  output logic [31:0]                      src_ip_out,
  output logic [31:0]                      dst_ip_out,
  output logic [7:0]                       icmp_msg_out,
  output logic [15:0]                      icmp_checksum_out
);
  import ipfw_pkg::*;

  cfg_t cfg;
  cls_t cls;
  logic accept;
  logic unused_cks;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready  = ~busy;
  assign accept     = start & ~busy;
  // received header checksum is recomputed, never checked
  assign unused_cks = ^ip_checksum_in;

  ipfw_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ipfw_classify u_cls (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .in_valid         (accept),
    .rx_port          (rx_port),
    .frame_type       (frame_type),
    .ip_front_bytes   (ip_front_bytes),
    .ttl_in           (ttl_in),
    .protocol         (protocol),
    .src_ip_in        (src_ip_in),
    .dst_ip_in        (dst_ip_in),
    .icmp_msg_in      (icmp_msg_in),
    .icmp_checksum_in (icmp_checksum_in),
    .cls              (cls)
  );

  ipfw_rewrite u_rw (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cls               (cls),
    .out_valid         (out_strobe),
    .action            (action),
    .tx_port           (tx_port),
    .dst_mac_out       (dst_mac_out),
    .src_mac_out       (src_mac_out),
    .ttl_out           (ttl_out),
    .ip_checksum_out   (ip_checksum_out),
    .src_ip_out        (src_ip_out),
    .dst_ip_out        (dst_ip_out),
    .icmp_msg_out      (icmp_msg_out),
    .icmp_checksum_out (icmp_checksum_out)
  );

endmodule

>>> hdl/ipfw_cfg_regs.sv
// Per-port MAC and IP register file of the rewrite block.
// Depends on ipfw_pkg.
module ipfw_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [ipfw_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [ipfw_pkg::CFG_DATA_W-1:0]    wr_data,
  output ipfw_pkg::cfg_t                     cfg
);
  import ipfw_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_mac0      <= '0;
      cfg.own_mac1      <= '0;
      cfg.next_hop_mac0 <= RST_NEXT_HOP_MAC0;
      cfg.next_hop_mac1 <= RST_NEXT_HOP_MAC1;
      cfg.own_ip0       <= RST_OWN_IP0;
      cfg.own_ip1       <= RST_OWN_IP1;
    end else if (wr_en) begin
      case (wr_index)
        REG_OWN_MAC0:      cfg.own_mac0      <= wr_data;
        REG_OWN_MAC1:      cfg.own_mac1      <= wr_data;
        REG_NEXT_HOP_MAC0: cfg.next_hop_mac0 <= wr_data;
        REG_NEXT_HOP_MAC1: cfg.next_hop_mac1 <= wr_data;
        REG_OWN_IP0:       cfg.own_ip0       <= wr_data[31:0];
        REG_OWN_IP1:       cfg.own_ip1       <= wr_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/ipfw_classify.sv
// First pipeline stage: drop / forward / echo reply decision, egress port
// and partial header sum of the front words. Depends on ipfw_pkg.
module ipfw_classify (
  input  logic                clk,
  input  logic                rst,
  input  ipfw_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  logic                rx_port,
  input  logic [15:0]         frame_type,
  input  logic [63:0]         ip_front_bytes,
  input  logic [7:0]          ttl_in,
  input  logic [7:0]          protocol,
  input  logic [31:0]         src_ip_in,
  input  logic [31:0]         dst_ip_in,
  input  logic [7:0]          icmp_msg_in,
  input  logic [15:0]         icmp_checksum_in,
  output ipfw_pkg::cls_t      cls
);
  import ipfw_pkg::*;

  logic        is_ipv4;
  logic        to_us;
  logic        is_echo_req;
  logic [31:0] rx_ip;
  action_t     action_next;
  logic        tx_port_next;
  logic [17:0] front_sum_next;

  always_comb begin
    rx_ip       = rx_port ? cfg.own_ip1 : cfg.own_ip0;
    is_ipv4     = (frame_type == ETHERTYPE_IPV4);
    to_us       = (dst_ip_in == rx_ip);
    is_echo_req = (protocol == PROTO_ICMP) && (icmp_msg_in == ICMP_ECHO_REQUEST);

    if (!is_ipv4)        action_next = ACT_DROP;
    else if (!to_us)     action_next = ACT_FORWARD;
    else if (is_echo_req) action_next = ACT_REPLY;
    else                 action_next = ACT_DROP;

    // reply leaves port 0 when it owns the address, else the ingress port
    if (to_us) tx_port_next = (dst_ip_in == cfg.own_ip0) ? 1'b0 : rx_port;
    else       tx_port_next = ~rx_port;

    front_sum_next = {2'b00, ip_front_bytes[63:48]} + {2'b00, ip_front_bytes[47:32]}
                   + {2'b00, ip_front_bytes[31:16]} + {2'b00, ip_front_bytes[15:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls.valid <= 1'b0;
    end else begin
      cls.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      cls.action    <= action_next;
      cls.tx_port   <= tx_port_next;
      cls.ttl       <= ttl_in;
      cls.proto     <= protocol;
      cls.src_ip    <= src_ip_in;
      cls.dst_ip    <= dst_ip_in;
      cls.icmp_msg  <= icmp_msg_in;
      cls.icmp_cks  <= icmp_checksum_in;
      cls.front_sum <= front_sum_next;
    end
  end

endmodule

>>> hdl/ipfw_rewrite.sv
// Second and third pipeline stages: field rewrite and header sum, then
// checksum fold and output register. Depends on ipfw_pkg and the assert header.
module ipfw_rewrite (
  input  logic            clk,
  input  logic            rst,
  input  ipfw_pkg::cfg_t  cfg,
  input  ipfw_pkg::cls_t  cls,
  output logic            out_valid,
  output logic [1:0]      action,
  output logic            tx_port,
  output logic [47:0]     dst_mac_out,
  output logic [47:0]     src_mac_out,
  output logic [7:0]      ttl_out,
  output logic [15:0]     ip_checksum_out,
  output logic [31:0]     src_ip_out,
  output logic [31:0]     dst_ip_out,
  output logic [7:0]      icmp_msg_out,
  output logic [15:0]     icmp_checksum_out
);
  import ipfw_pkg::*;
  `include "ipv4_forward_and_echo_reply_rewrite_core_assert.svh"

  // stage 2 registers
  logic        s2_valid;
  action_t     s2_action;
  logic        s2_tx_port;
  logic [47:0] s2_dst_mac;
  logic [47:0] s2_src_mac;
  logic [7:0]  s2_ttl;
  logic [31:0] s2_src_ip;
  logic [31:0] s2_dst_ip;
  logic [7:0]  s2_icmp_msg;
  logic [15:0] s2_icmp_cks;
  logic [19:0] s2_ip_sum;
  logic [16:0] s2_icmp_sum;

  logic        is_reply;
  logic [7:0]  ttl_next;
  logic [19:0] ip_sum_next;
  logic [16:0] icmp_sum_next;

  always_comb begin
    is_reply      = (cls.action == ACT_REPLY);
    ttl_next      = is_reply ? REPLY_TTL : cls.ttl - 8'd1;
    // address words add the same either way round
    ip_sum_next   = {2'b00, cls.front_sum} + {4'h0, ttl_next, cls.proto}
                  + {4'h0, cls.src_ip[31:16]} + {4'h0, cls.src_ip[15:0]}
                  + {4'h0, cls.dst_ip[31:16]} + {4'h0, cls.dst_ip[15:0]};
    icmp_sum_next = {1'b0, ~cls.icmp_cks} + {1'b0, ~{cls.icmp_msg, 8'h00}}
                  + {1'b0, ICMP_ECHO_REPLY, 8'h00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= cls.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cls.valid) begin
      s2_action    <= cls.action;
      s2_tx_port   <= cls.tx_port;
      s2_dst_mac   <= cls.tx_port ? cfg.next_hop_mac1 : cfg.next_hop_mac0;
      s2_src_mac   <= cls.tx_port ? cfg.own_mac1 : cfg.own_mac0;
      s2_ttl       <= ttl_next;
      s2_src_ip    <= is_reply ? cls.dst_ip : cls.src_ip;
      s2_dst_ip    <= is_reply ? cls.src_ip : cls.dst_ip;
      s2_icmp_msg  <= is_reply ? ICMP_ECHO_REPLY : cls.icmp_msg;
      s2_icmp_cks  <= cls.icmp_cks;
      s2_ip_sum    <= ip_sum_next;
      s2_icmp_sum  <= icmp_sum_next;
    end
  end

  // stage 3: fold, complement, zero on drop
  logic [16:0] ip_f1;
  logic [16:0] ip_f2;
  logic [16:0] ic_f1;
  logic [16:0] ic_f2;
  logic        s2_drop;

  always_comb begin
    ip_f1   = {1'b0, s2_ip_sum[15:0]} + {13'h0, s2_ip_sum[19:16]};
    ip_f2   = {1'b0, ip_f1[15:0]} + {16'h0, ip_f1[16]};
    ic_f1   = {1'b0, s2_icmp_sum[15:0]} + {16'h0, s2_icmp_sum[16]};
    ic_f2   = {1'b0, ic_f1[15:0]} + {16'h0, ic_f1[16]};
    s2_drop = (s2_action == ACT_DROP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      action <= s2_action;
      if (s2_drop) begin
        tx_port           <= 1'b0;
        dst_mac_out       <= '0;
        src_mac_out       <= '0;
        ttl_out           <= '0;
        ip_checksum_out   <= '0;
        src_ip_out        <= '0;
        dst_ip_out        <= '0;
        icmp_msg_out      <= '0;
        icmp_checksum_out <= '0;
      end else begin
        tx_port           <= s2_tx_port;
        dst_mac_out       <= s2_dst_mac;
        src_mac_out       <= s2_src_mac;
        ttl_out           <= s2_ttl;
        ip_checksum_out   <= ~ip_f2[15:0];
        src_ip_out        <= s2_src_ip;
        dst_ip_out        <= s2_dst_ip;
        icmp_msg_out      <= s2_icmp_msg;
        icmp_checksum_out <= (s2_action == ACT_REPLY) ? ~ic_f2[15:0] : s2_icmp_cks;
      end
    end
  end

  `IPFW_ASSERT(a_latency, clk, rst, out_valid |-> $past(cls.valid, 2), "result without beat")
  `IPFW_ASSERT(a_drop_zero, clk, rst, (out_valid && action == ACT_DROP) |-> (ttl_out == 8'd0 && dst_ip_out == 32'd0 && src_mac_out == 48'd0 && ip_checksum_out == 16'd0), "drop not cleared")
  `IPFW_ASSERT(a_reply_fields, clk, rst, (out_valid && action == ACT_REPLY) |-> (ttl_out == REPLY_TTL && icmp_msg_out == ICMP_ECHO_REPLY), "bad reply fields")
  `IPFW_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !out_valid && !s2_valid, "valid after reset")

endmodule

>>> dv/ipv4_forward_and_echo_reply_rewrite_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the IPv4 forward / echo reply header rewrite core.
// Needs ipfw_pkg and the core RTL; directed table, then random headers over
// several register settings, each result checked against a pinned value or an in-bench model.
module ipv4_forward_and_echo_reply_rewrite_core_tb;
  import ipfw_pkg::*;

  localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam int N_PHASES   = 6;
  localparam int PHASE_HDRS = 275;
  localparam int IDLE_PCT [4] = '{0, 77, 0, 12};

  typedef struct packed {
    logic        rx;
    logic [15:0] etype;
    logic [63:0] front;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [15:0] ip_cks;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  icmp_msg;
    logic [15:0] icmp_cks;
  } hdr_t;

  typedef struct packed {
    action_t     act;
    logic        tx;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [7:0]  ttl;
    logic [15:0] ip_cks;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  icmp_msg;
    logic [15:0] icmp_cks;
  } rewrite_t;

  typedef struct packed {
    hdr_t     h;
    logic     pinned;
    rewrite_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  rx_port;
  logic [15:0]           frame_type;
  logic [63:0]           ip_front_bytes;
  logic [7:0]            ttl_in;
  logic [7:0]            protocol;
  logic [15:0]           ip_checksum_in;
  logic [31:0]           src_ip_in;
  logic [31:0]           dst_ip_in;
  logic [7:0]            icmp_msg_in;
  logic [15:0]           icmp_checksum_in;
  logic                  out_strobe;
  logic [1:0]            action;
  logic                  tx_port;
  logic [47:0]           dst_mac_out;
  logic [47:0]           src_mac_out;
  logic [7:0]            ttl_out;
  logic [15:0]           ip_checksum_out;
  logic [31:0]           src_ip_out;
  logic [31:0]           dst_ip_out;
  logic [7:0]            icmp_msg_out;
  logic [15:0]           icmp_checksum_out;

  cfg_t       router_cfg;
  rewrite_t   pending_rewrites[$];
  dir_row_t   dir_rows[$];
  int         mismatches;
  int         hdrs_sent;
  int         reg_writes;
  int         n_fwd;
  int         n_reply;
  int         n_drop;

  ipv4_forward_and_echo_reply_rewrite_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [15:0] fold_ones(input logic [31:0] s);
    s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    s = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    return s[15:0];
  endfunction

  function automatic logic [15:0] ipv4_hdr_cks(input hdr_t h, input logic [7:0] ttl,
                                               input logic [31:0] src,
                                               input logic [31:0] dst);
    logic [31:0] s;
    s = {16'h0, h.front[63:48]} + {16'h0, h.front[47:32]} + {16'h0, h.front[31:16]}
      + {16'h0, h.front[15:0]} + {16'h0, ttl, h.proto} + {16'h0, src[31:16]}
      + {16'h0, src[15:0]} + {16'h0, dst[31:16]} + {16'h0, dst[15:0]};
    return ~fold_ones(s);
  endfunction

  // incremental update: only the type byte of the first ICMP word changes
  function automatic logic [15:0] echo_reply_icmp_cks(input logic [15:0] hc,
                                                      input logic [7:0] old_msg);
    logic [15:0] nhc;
    logic [15:0] nold;
    logic [31:0] s;
    nhc  = ~hc;
    nold = ~{old_msg, 8'h00};
    s = {16'h0, nhc} + {16'h0, nold} + {16'h0, ICMP_ECHO_REPLY, 8'h00};
    return ~fold_ones(s);
  endfunction

  function automatic rewrite_t rewrite_header(input hdr_t h, input cfg_t c);
    rewrite_t    r;
    logic [31:0] rx_ip;
    r = '0;
    if (h.etype != ETHERTYPE_IPV4) return r;
    rx_ip = h.rx ? c.own_ip1 : c.own_ip0;
    if (h.dst == rx_ip) begin
      if (h.proto != PROTO_ICMP || h.icmp_msg != ICMP_ECHO_REQUEST) return r;
      r.act       = ACT_REPLY;
      r.tx        = (h.dst == c.own_ip0) ? 1'b0 : h.rx;
      r.ttl       = REPLY_TTL;
      r.src_ip    = h.dst;
      r.dst_ip    = h.src;
      r.icmp_msg  = ICMP_ECHO_REPLY;
      r.icmp_cks  = echo_reply_icmp_cks(h.icmp_cks, h.icmp_msg);
    end else begin
      r.act       = ACT_FORWARD;
      r.tx        = ~h.rx;
      r.ttl       = h.ttl - 8'd1;
      r.src_ip    = h.src;
      r.dst_ip    = h.dst;
      r.icmp_msg  = h.icmp_msg;
      r.icmp_cks  = h.icmp_cks;
    end
    r.dst_mac = r.tx ? c.next_hop_mac1 : c.next_hop_mac0;
    r.src_mac = r.tx ? c.own_mac1 : c.own_mac0;
    r.ip_cks  = ipv4_hdr_cks(h, r.ttl, r.src_ip, r.dst_ip);
    return r;
  endfunction

  function automatic hdr_t hdr(input logic rx, input logic [15:0] etype,
                               input logic [63:0] front, input logic [7:0] ttl,
                               input logic [7:0] proto, input logic [15:0] ip_cks,
                               input logic [31:0] src, input logic [31:0] dst,
                               input logic [7:0] icmp_msg, input logic [15:0] icmp_cks);
    hdr_t h;
    h = '{rx, etype, front, ttl, proto, ip_cks, src, dst, icmp_msg, icmp_cks};
    return h;
  endfunction

  function automatic hdr_t rand_header(input cfg_t c);
    hdr_t        h;
    int unsigned kind;
    logic [31:0] own;
    h.rx        = 1'($urandom);
    h.etype     = ETHERTYPE_IPV4;
    h.front     = {$urandom, $urandom};
    h.ttl       = 8'($urandom);
    h.proto     = 8'($urandom);
    h.ip_cks    = 16'($urandom);
    h.src       = $urandom;
    h.dst       = $urandom;
    h.icmp_msg  = 8'($urandom);
    h.icmp_cks  = 16'($urandom);
    if ($urandom_range(7) == 0)
      h.ttl = ($urandom_range(1) == 1) ? 8'h00 : (($urandom_range(1) == 1) ? 8'h01 : 8'hFF);
    own  = h.rx ? c.own_ip1 : c.own_ip0;
    kind = $urandom_range(99);
    if (kind < 40) begin
      if ($urandom_range(1) == 1) h.proto = PROTO_ICMP;
      if ($urandom_range(1) == 1) h.icmp_msg = ICMP_ECHO_REQUEST;
      if ($urandom_range(3) == 0) h.dst = h.rx ? c.own_ip0 : c.own_ip1;
      if (h.dst == own) h.dst = h.dst ^ 32'h1;
    end else if (kind < 70) begin
      h.dst       = own;
      h.proto     = PROTO_ICMP;
      h.icmp_msg  = ICMP_ECHO_REQUEST;
    end else if (kind < 78) begin
      h.dst = own;
      if ($urandom_range(1) == 1) h.proto = PROTO_ICMP;
    end else if (kind < 88) begin
      h.etype = ($urandom_range(1) == 1) ? ETHERTYPE_ARP : 16'($urandom);
    end else begin
      h.etype = 16'($urandom);
    end
    return h;
  endfunction

  function automatic string fmt(input rewrite_t r);
    return $sformatf("act=%0d tx=%0d dmac=%h smac=%h ttl=%h ipck=%h sip=%h dip=%h ityp=%h ick=%h",
                     r.act, r.tx, r.dst_mac, r.src_mac, r.ttl, r.ip_cks, r.src_ip, r.dst_ip,
                     r.icmp_msg, r.icmp_cks);
  endfunction

  task automatic note_fail(input string what, input rewrite_t want, input rewrite_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $realtime, what);
      $display("  expected %s", fmt(want));
      $display("  actual   %s", fmt(got));
    end
  endtask

  always @(posedge clk) begin : result_check
    rewrite_t got;
    rewrite_t want;
    string    bad;
    if (!rst && out_strobe) begin
      got = '{action_t'(action), tx_port, dst_mac_out, src_mac_out, ttl_out, ip_checksum_out,
              src_ip_out, dst_ip_out, icmp_msg_out, icmp_checksum_out};
      if (pending_rewrites.size() == 0) begin
        note_fail("result beat with nothing outstanding", '0, got);
      end else begin
        want = pending_rewrites.pop_front();
        bad  = "";
        if (got.act != want.act) bad = {bad, " action"};
        if (got.tx != want.tx) bad = {bad, " tx_port"};
        if (got.dst_mac != want.dst_mac) bad = {bad, " dst_mac_out"};
        if (got.src_mac != want.src_mac) bad = {bad, " src_mac_out"};
        if (got.ttl != want.ttl) bad = {bad, " ttl_out"};
        if (got.ip_cks != want.ip_cks) bad = {bad, " ip_checksum_out"};
        if (got.src_ip != want.src_ip) bad = {bad, " src_ip_out"};
        if (got.dst_ip != want.dst_ip) bad = {bad, " dst_ip_out"};
        if (got.icmp_msg != want.icmp_msg) bad = {bad, " icmp_msg_out"};
        if (got.icmp_cks != want.icmp_cks) bad = {bad, " icmp_checksum_out"};
        if (bad != "") note_fail({"mismatch on", bad}, want, got);
        case (want.act)
          ACT_FORWARD: n_fwd++;
          ACT_REPLY:   n_reply++;
          default:     n_drop++;
        endcase
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat, start still high
  task automatic send_header(input hdr_t h, input logic pinned, input rewrite_t fixed);
    start            <= 1'b1;
    rx_port          <= h.rx;
    frame_type       <= h.etype;
    ip_front_bytes   <= h.front;
    ttl_in           <= h.ttl;
    protocol         <= h.proto;
    ip_checksum_in   <= h.ip_cks;
    src_ip_in        <= h.src;
    dst_ip_in        <= h.dst;
    icmp_msg_in      <= h.icmp_msg;
    icmp_checksum_in <= h.icmp_cks;
    do @(posedge clk); while (busy);
    pending_rewrites.push_back(pinned ? fixed : rewrite_header(h, router_cfg));
    hdrs_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_OWN_MAC0:      router_cfg.own_mac0      = data;
      REG_OWN_MAC1:      router_cfg.own_mac1      = data;
      REG_NEXT_HOP_MAC0: router_cfg.next_hop_mac0 = data;
      REG_NEXT_HOP_MAC1: router_cfg.next_hop_mac1 = data;
      REG_OWN_IP0:       router_cfg.own_ip0       = data[31:0];
      REG_OWN_IP1:       router_cfg.own_ip1       = data[31:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic program_cfg(input cfg_t c, input logic spares);
    if (spares) write_reg(REG_SPARE_A, 48'({$urandom, $urandom}));
    write_reg(REG_OWN_MAC0, c.own_mac0);
    write_reg(REG_OWN_MAC1, c.own_mac1);
    write_reg(REG_NEXT_HOP_MAC0, c.next_hop_mac0);
    write_reg(REG_NEXT_HOP_MAC1, c.next_hop_mac1);
    write_reg(REG_OWN_IP0, {16'($urandom), c.own_ip0});
    write_reg(REG_OWN_IP1, {16'($urandom), c.own_ip1});
    if (spares) write_reg(REG_SPARE_B, 48'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_rewrites.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_row(input hdr_t h, input logic pinned, input rewrite_t want);
    dir_row_t r;
    r.h      = h;
    r.pinned = pinned;
    r.want   = want;
    dir_rows.push_back(r);
  endtask

  initial begin : stimulus
    cfg_t c;
    int   pct;
    int   waited;
    start            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    rx_port          = 1'b0;
    frame_type       = '0;
    ip_front_bytes   = '0;
    ttl_in           = '0;
    protocol         = '0;
    ip_checksum_in   = '0;
    src_ip_in        = '0;
    dst_ip_in        = '0;
    icmp_msg_in      = '0;
    icmp_checksum_in = '0;
    rst              = 1'b1;
    mismatches = 0;
    hdrs_sent  = 0;
    reg_writes = 0;
    n_fwd      = 0;
    n_reply    = 0;
    n_drop     = 0;
    router_cfg = '{48'h0, 48'h0, RST_NEXT_HOP_MAC0, RST_NEXT_HOP_MAC1, RST_OWN_IP0, RST_OWN_IP1};

    // reset register values
    add_row(hdr(1'b0, ETHERTYPE_ARP, 64'h0001_0800_0604_0001, 8'h40, PROTO_ICMP, 16'h1234,
                32'hC0A8_0B02, RST_OWN_IP0, ICMP_ECHO_REQUEST, 16'hABCD), 1'b1, '0);
    add_row(hdr(1'b1, 16'hFFFF, '1, 8'hFF, 8'hFF, 16'hFFFF, '1, '1, 8'hFF, 16'hFFFF),
            1'b1, '0);
    add_row(hdr(1'b1, 16'h0000, '0, 8'h00, 8'h00, 16'h0000, '0, '0, 8'h00, 16'h0000),
            1'b1, '0);
    add_row(hdr(1'b0, 16'h0801, 64'h4500_0054_0000_4000, 8'h40, PROTO_ICMP, 16'h0,
                32'h0A00_0001, 32'h0A00_0002, ICMP_ECHO_REQUEST, 16'h0), 1'b1, '0);
    add_row(hdr(1'b1, ETHERTYPE_IPV4, '0, 8'h00, 8'h00, 16'h0000, '0, '0, 8'h00, 16'h0000),
            1'b1, rewrite_t'{ACT_FORWARD, 1'b0, RST_NEXT_HOP_MAC0, 48'h0, 8'hFF, 16'h00FF,
                             32'h0, 32'h0, 8'h00, 16'h0000});
    add_row(hdr(1'b0, ETHERTYPE_IPV4, '1, 8'hFF, 8'hFF, 16'hFFFF, '1, '1, 8'hFF, 16'hFFFF),
            1'b1, rewrite_t'{ACT_FORWARD, 1'b1, RST_NEXT_HOP_MAC1, 48'h0, 8'hFE, 16'h0100,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF});
    add_row(hdr(1'b0, ETHERTYPE_IPV4, 64'h4500_0028_1111_0000, 8'h40, PROTO_TCP, 16'h0,
                32'h0A01_0203, RST_OWN_IP0, ICMP_ECHO_REQUEST, 16'h5555), 1'b1, '0);
    add_row(hdr(1'b0, ETHERTYPE_IPV4, 64'h4500_0054_2222_0000, 8'h40, PROTO_ICMP, 16'h0,
                32'h0A01_0203, RST_OWN_IP0, ICMP_ECHO_REPLY, 16'h5555), 1'b1, '0);
    add_row(hdr(1'b1, ETHERTYPE_IPV6, 64'h4500_0054_3333_0000, 8'h40, PROTO_ICMP, 16'h0,
                32'h0A01_0203, RST_OWN_IP1, ICMP_ECHO_REQUEST, 16'h5555), 1'b1, '0);
    // the rest go through the model
    add_row(hdr(1'b1, ETHERTYPE_IPV4, 64'h4500_0054_1c46_4000, 8'h40, PROTO_ICMP, 16'hBEEF,
                32'hC0A8_0C0A, RST_OWN_IP1, ICMP_ECHO_REQUEST, 16'h4D2A), 1'b0, '0);
    add_row(hdr(1'b0, ETHERTYPE_IPV4, 64'h4500_0054_0001_0000, 8'h80, PROTO_ICMP, 16'h0,
                32'hC0A8_0B0A, RST_OWN_IP0, ICMP_ECHO_REQUEST, 16'h0000), 1'b0, '0);
    add_row(hdr(1'b0, ETHERTYPE_IPV4, 64'h4500_0054_0002_0000, 8'h01, PROTO_ICMP, 16'h0,
                32'hC0A8_0B0A, RST_OWN_IP0, ICMP_ECHO_REQUEST, 16'hFFFF), 1'b0, '0);
    add_row(hdr(1'b1, ETHERTYPE_IPV4, '1, 8'h00, PROTO_ICMP, 16'hFFFF, '1, RST_OWN_IP1,
                ICMP_ECHO_REQUEST, 16'hF7FF), 1'b0, '0);
    add_row(hdr(1'b0, ETHERTYPE_IPV4, 64'h4500_0054_0003_0000, 8'h40, PROTO_ICMP, 16'h0,
                32'h0A00_0001, RST_OWN_IP1, ICMP_ECHO_REQUEST, 16'h1111), 1'b0, '0);
    add_row(hdr(1'b1, ETHERTYPE_IPV4, 64'h4500_0054_0004_0000, 8'h40, PROTO_ICMP, 16'h0,
                32'h0A00_0001, RST_OWN_IP0, ICMP_ECHO_REQUEST, 16'h2222), 1'b0, '0);
    add_row(hdr(1'b0, ETHERTYPE_IPV4, 64'h4500_0028_0005_4000, 8'h01, PROTO_TCP, 16'hDEAD,
                32'h0A00_0001, 32'h0808_0808, 8'h00, 16'h0000), 1'b0, '0);
    add_row(hdr(1'b1, ETHERTYPE_IPV4, 64'h4500_0054_0006_0000, 8'h40, PROTO_ICMP, 16'h0,
                32'hC0A8_0C0A, 32'h0808_0808, ICMP_ECHO_REQUEST, 16'h3333), 1'b0, '0);
    add_row(hdr(1'b0, ETHERTYPE_IPV4, 64'hAAAA_5555_AAAA_5555, 8'hAA, 8'h55, 16'hA5A5,
                32'h5555_AAAA, 32'hAAAA_5555, 8'h55, 16'h5AA5), 1'b0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_header(dir_rows[i].h, dir_rows[i].pinned, dir_rows[i].want);
    start <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      c = router_cfg;
      case (p)
        1: c = '0;
        2: c = '1;
        3, 4, 5: begin
          c = '{48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom, $urandom};
          if (p == 4) c.own_ip1 = c.own_ip0;
        end
        default: ;
      endcase
      if (p != 0) program_cfg(c, p == 5);
      pct = IDLE_PCT[p % 4];
      for (int i = 0; i < PHASE_HDRS; i++) begin
        send_header(rand_header(router_cfg), 1'b0, '0);
        if ($urandom_range(99) < pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(negedge clk);
        end
      end
      start <= 1'b0;
    end

    waited = 0;
    while (pending_rewrites.size() != 0 && waited < 100) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (pending_rewrites.size() != 0) begin
      $display("%0d headers never produced a result", pending_rewrites.size());
      mismatches += pending_rewrites.size();
    end

    $display("%0d headers over %0d register settings: %0d forwarded, %0d echo replies, %0d dropped",
             hdrs_sent, N_PHASES, n_fwd, n_reply, n_drop);
    $display("%0d register writes, %0d failures", reg_writes, mismatches);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
